// ===== src/rgb_matrix_pwm_scanner_defines.svh =====
// Assertion macros used by the checker file of the LED matrix scanner.
`ifndef RGB_MATRIX_PWM_SCANNER_DEFINES_SVH
`define RGB_MATRIX_PWM_SCANNER_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define RMPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define RMPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rmps_pkg.sv =====
// Shared types and constants of the LED matrix PWM scanner.
package rmps_pkg;

  // Request action codes
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_WR_FULL = 2'd1;
  localparam logic [1:0] ACT_WR_BIT  = 2'd2;

  // Color planes
  localparam logic [1:0] PLANE_BLUE  = 2'd0;
  localparam logic [1:0] PLANE_GREEN = 2'd1;
  localparam logic [1:0] PLANE_RED   = 2'd2;
  localparam int         NUM_PLANES  = 3;

  // Stored intensity level
  localparam int                 LEVEL_W   = 6;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 6'h3f;

  // One level write into the store
  typedef struct packed {
    logic               en;
    logic [2:0]         row;
    logic [3:0]         col;
    logic [1:0]         plane;
    logic [LEVEL_W-1:0] level;
  } wr_t;

endpackage

// ===== src/rmps_ifs.sv =====
// Request and result channel interfaces of the LED matrix PWM scanner.
interface rmps_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] row;
  logic [2:0] column;
  logic [1:0] color;
  logic [7:0] value;

  modport source (output valid, action, row, column, color, value, input ready);
  modport sink   (input valid, action, row, column, color, value, output ready);
endinterface

interface rmps_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_drive;
  logic [7:0] blue_bits;
  logic [7:0] green_bits;
  logic [7:0] red_bits;

  modport source (output valid, row_drive, blue_bits, green_bits, red_bits, input ready);
  modport sink   (input valid, row_drive, blue_bits, green_bits, red_bits, output ready);
endinterface

// ===== src/rgb_matrix_pwm_scanner.sv =====
// Top level of the row-scanned RGB LED matrix PWM scanner.
// Takes one request per cycle: a write stores one 6-bit level, a tick returns the
// active-low row select and one on/off bit per column and color for the current
// PWM step, then advances the step (and the scan row on wrap). A tick's result
// reaches the result register in order: the per-column level RAMs are read at
// the accepting edge, and the compare is registered when the pipe advances.
// The only stall is a full result register that the sink does not take. The
// store reads as all zero after reset with no clearing pass (per-entry written
// flags).
module rgb_matrix_pwm_scanner import rmps_pkg::*; #(
  parameter int ROWS      = 8,
  parameter int COLUMNS   = 8,
  parameter int PWM_STEPS = 64
) (
  input  logic          clk,
  input  logic          rst,
  rmps_item_if.sink     item,
  rmps_result_if.source result
);

  localparam int RW    = $clog2(ROWS);
  localparam int SW    = $clog2(PWM_STEPS);
  localparam int LANES = (COLUMNS < 8) ? COLUMNS : 8;

  logic               adv, take, tick;
  logic               full, onebit;
  logic [3:0]         col_mir;
  wr_t                wr;
  logic [RW-1:0]      scan_row;
  logic [SW-1:0]      pwm_step;
  logic               s_tick;
  logic [RW-1:0]      s_row;
  logic [SW-1:0]      s_step;
  logic [LEVEL_W-1:0] lvl [NUM_PLANES][LANES];

  // Whole pipe moves unless the result register is full and stalled
  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;
  assign take       = item.valid && adv;
  assign tick       = take && (item.action == ACT_TICK);

  // Write decode: range checks, green mirroring, level mapping
  assign full    = item.action == ACT_WR_FULL;
  assign onebit  = item.action == ACT_WR_BIT;
  assign col_mir = 4'(COLUMNS - 1) - {1'b0, item.column};

  always_comb begin
    wr.en    = take && (full || onebit) && (item.color <= PLANE_RED)
               && ({2'b00, item.row} < 5'(ROWS))
               && ({2'b00, item.column} < 5'(COLUMNS));
    wr.row   = item.row;
    wr.plane = item.color;
    wr.col   = (full && item.color == PLANE_GREEN) ? col_mir : {1'b0, item.column};
    if (full) begin
      wr.level = item.value[7:2];
    end else begin
      wr.level = item.value[0] ? LEVEL_MAX : '0;
    end
  end

  // PWM step and scan row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_step <= '0;
      scan_row <= '0;
    end else if (tick) begin
      if (pwm_step == SW'(PWM_STEPS - 1)) begin
        pwm_step <= '0;
        scan_row <= (scan_row == RW'(ROWS - 1)) ? '0 : scan_row + 1'b1;
      end else begin
        pwm_step <= pwm_step + 1'b1;
      end
    end
  end

  // Tick context travels beside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s_tick <= 1'b0;
    end else if (adv) begin
      s_tick <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_row  <= scan_row;
      s_step <= pwm_step;
    end
  end

  rmps_store #(
    .ROWS  (ROWS),
    .LANES (LANES)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_en  (adv),
    .rd_row (scan_row),
    .lvl    (lvl)
  );

  rmps_shade #(
    .LANES (LANES),
    .RW    (RW),
    .SW    (SW)
  ) u_shade (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .s_tick (s_tick),
    .s_row  (s_row),
    .s_step (s_step),
    .lvl    (lvl),
    .result (result)
  );

endmodule

// ===== src/rmps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rmps_store.sv =====
// Level store: one small RAM per color plane and column, indexed by row.
module rmps_store import rmps_pkg::*; #(
  parameter int ROWS  = 8,
  parameter int LANES = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  wr_t                      wr,
  input  logic                     rd_en,
  input  logic [$clog2(ROWS)-1:0]  rd_row,
  output logic [LEVEL_W-1:0]       lvl [NUM_PLANES][LANES]
);

  localparam int RW = $clog2(ROWS);

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    for (genvar c = 0; c < LANES; c++) begin : g_lane
      logic               we;
      logic [RW-1:0]      waddr;
      logic [LEVEL_W-1:0] rdata;
      logic [ROWS-1:0]    vld;
      logic               vld_q;

      assign we    = wr.en && (wr.plane == 2'(p)) && (wr.col == 4'(c));
      assign waddr = RW'(wr.row);

      rmps_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (ROWS)
      ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr.level),
        .re    (rd_en),
        .raddr (rd_row),
        .rdata (rdata)
      );

      // Written flags: an unwritten entry reads as level zero
      always_ff @(posedge clk) begin
        if (rst) begin
          vld   <= '0;
          vld_q <= 1'b0;
        end else begin
          if (we) begin
            vld[waddr] <= 1'b1;
          end
          if (rd_en) begin
            vld_q <= vld[rd_row];
          end
        end
      end

      assign lvl[p][c] = vld_q ? rdata : '0;
    end
  end

endmodule

// ===== src/rmps_shade.sv =====
// Column compare against the PWM step and the result register.
module rmps_shade import rmps_pkg::*; #(
  parameter int LANES = 8,
  parameter int RW    = 3,
  parameter int SW    = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 s_tick,
  input  logic [RW-1:0]        s_row,
  input  logic [SW-1:0]        s_step,
  input  logic [LEVEL_W-1:0]   lvl [NUM_PLANES][LANES],
  rmps_result_if.source        result
);

  localparam int CW = (SW > LEVEL_W) ? SW : LEVEL_W;

  logic        res_valid;
  logic [7:0]  row_drive, blue_bits, green_bits, red_bits;
  logic [7:0]  plane_bits [NUM_PLANES];
  logic [7:0]  row_sel;

  // Bit is set when the level is at most the step; missing columns stay 0
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      plane_bits[p] = '0;
      for (int c = 0; c < LANES; c++) begin
        plane_bits[p][c] = CW'(lvl[p][c]) <= CW'(s_step);
      end
    end
  end

  // Rows past the eighth leave all selects high
  assign row_sel = 8'(16'(1) << s_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_tick) begin
      row_drive  <= ~row_sel;
      blue_bits  <= plane_bits[PLANE_BLUE];
      green_bits <= plane_bits[PLANE_GREEN];
      red_bits   <= plane_bits[PLANE_RED];
    end
  end

  assign result.valid      = res_valid;
  assign result.row_drive  = row_drive;
  assign result.blue_bits  = blue_bits;
  assign result.green_bits = green_bits;
  assign result.red_bits   = red_bits;

endmodule

// ===== src/rmps_checker.sv =====
// Port-level checker for the LED matrix PWM scanner, bound to the top level.
`include "rgb_matrix_pwm_scanner_defines.svh"

module rmps_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] row_drive,
  input logic [7:0] blue_bits,
  input logic [7:0] green_bits,
  input logic [7:0] red_bits
);

  // No result may come out of reset
  `RMPS_ASSERT_RST(a_rst_empty, rst |=> !res_valid, "result valid right after reset")

  // Requests only back up behind a full result register
  `RMPS_ASSERT(a_ready_free, !res_valid |-> item_ready, "request stalled with empty output")

  // At most one row is driven at a time
  `RMPS_ASSERT(a_one_row,
    res_valid |-> ($countones(row_drive) == 7 || row_drive == 8'hff),
    "more than one row selected")

  // A stalled result keeps its value
  `RMPS_ASSERT(a_hold,
    res_valid && !res_ready |=> res_valid && $stable(row_drive)
      && $stable(blue_bits) && $stable(green_bits) && $stable(red_bits),
    "stalled result changed")

endmodule

bind rgb_matrix_pwm_scanner rmps_checker u_rmps_checker (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .row_drive  (result.row_drive),
  .blue_bits  (result.blue_bits),
  .green_bits (result.green_bits),
  .red_bits   (result.red_bits)
);
